// ===== hw/rtl/tcw_pkg.sv =====
// Shared constants, codes and types of the text console writer.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF    = 25;

   localparam int FUNC_W  = 2;
   localparam int CHAR_W  = 8;
   localparam int ATTR_W  = 8;
   localparam int INDEX_W = 11;
   localparam int COL_FW  = 7;
   localparam int ROW_FW  = 5;
   localparam int HW_W    = 11;
   localparam int CELL_W  = CHAR_W + ATTR_W;

   localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_NL      = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_CR      = 8'h0D;
   localparam logic [ATTR_W-1:0] DEFAULT_ATTR = 8'h07;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUT   = 2'd0,
      FUNC_CLEAR = 2'd1,
      FUNC_LATCH = 2'd2,
      FUNC_READ  = 2'd3
   } func_type;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [CHAR_W-1:0]  chr;
      logic [INDEX_W-1:0] cell_index;
   } req_type;

endpackage

`default_nettype wire

// ===== hw/rtl/tcw_if.sv =====
// Request, response and register-write channel interfaces of the text console writer.
`timescale 1ns / 1ps
`default_nettype none

interface tcw_req_if import tcw_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FUNC_W-1:0]  func;
   logic [CHAR_W-1:0]  chr;
   logic [INDEX_W-1:0] cell_index;

   modport source(output valid, func, chr, cell_index, input ready);
   modport sink(input valid, func, chr, cell_index, output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [COL_FW-1:0] cursor_col;
   logic [ROW_FW-1:0] cursor_row;
   logic [HW_W-1:0]   hw_cursor_pos;
   logic [CHAR_W-1:0] cell_char;
   logic [ATTR_W-1:0] cell_attr;
   logic              scrolled;

   modport source(output valid, cursor_col, cursor_row, hw_cursor_pos, cell_char,
                  cell_attr, scrolled, input ready);
   modport sink(input valid, cursor_col, cursor_row, hw_cursor_pos, cell_char,
                cell_attr, scrolled, output ready);
endinterface

interface tcw_csr_if import tcw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ATTR_W-1:0] data;

   modport source(output valid, data, input ready);
   modport sink(input valid, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/text_console_writer.sv =====
// Top level of the text console writer: sequencer, cursor state and screen store.
`timescale 1ns / 1ps
`default_nettype none

// Text-mode console engine over a COLUMNS x ROWS store of 16-bit cells (attribute in the
// high byte, character in the low byte), held in one single-port-write RAM. After reset
// the block sweeps the store to blanks with attribute 7, one cell a cycle, before
// req_chan.ready first rises; register writes are taken meanwhile. One request is worked
// at a time: a put of an ordinary character, newline, carriage return or a cursor latch
// goes from acceptance through the execute state to the response state; a cell read
// passes an extra read state, as the RAM read is registered. Clear screen walks the whole
// store through the one RAM write port, one cell a cycle. A put that moves past the last
// row scrolls: each cell is copied one row up through the RAM read port and the bottom
// row is blanked with the current attribute. A finished response waits in its own
// register, so a new request is accepted while it is still unread.
module text_console_writer import tcw_pkg::*; #(
   parameter int COLUMNS = COLUMNS_DEF,
   parameter int ROWS    = ROWS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   tcw_req_if.sink    req_chan,
   tcw_rsp_if.source  rsp_chan,
   tcw_csr_if.sink    csr_chan
);

   localparam int NCELLS   = COLUMNS * ROWS;
   localparam int ADDR_W   = $clog2(NCELLS);
   localparam int COL_W    = $clog2(COLUMNS);
   localparam int ROW_W    = $clog2(ROWS);
   localparam int COPY_END = NCELLS - COLUMNS;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NCELLS - 1);
   localparam logic [ADDR_W-1:0] COPY_LIM  = ADDR_W'(COPY_END);
   localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);
   localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_EXEC   = 7'b0000010,
      S_FILL   = 7'b0000100,
      S_SCROLL = 7'b0001000,
      S_READ   = 7'b0010000,
      S_RESP   = 7'b0100000,
      S_FLUSH  = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [HW_W-1:0]    hw_ff, hw_in;
   logic [ATTR_W-1:0]  attr_ff, attr_in;
   logic [ADDR_W-1:0]  cnt_ff, cnt_in;
   logic               fill_rsp_ff, fill_rsp_in;
   logic               scrolled_ff, scrolled_in;
   logic               rd_ok_ff, rd_ok_in;
   logic [CHAR_W-1:0]  res_char_ff, res_char_in;
   logic [ATTR_W-1:0]  res_attr_ff, res_attr_in;

   logic               wr_en_ff, wr_en_in;
   logic [ADDR_W-1:0]  wr_addr_ff, wr_addr_in;
   logic               wr_copy_ff, wr_copy_in;
   logic [CELL_W-1:0]  wr_data_ff, wr_data_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [COL_FW-1:0]  rsp_col_ff, rsp_col_in;
   logic [ROW_FW-1:0]  rsp_row_ff, rsp_row_in;
   logic [HW_W-1:0]    rsp_hw_ff, rsp_hw_in;
   logic [CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic [ATTR_W-1:0]  rsp_attr_ff, rsp_attr_in;
   logic               rsp_scr_ff, rsp_scr_in;

   logic [ADDR_W-1:0]  rd_addr;
   logic [CELL_W-1:0]  rd_data;
   logic [CELL_W-1:0]  ram_wdata;
   logic [ADDR_W-1:0]  cur_pos;
   logic [ADDR_W-1:0]  src_addr;
   logic               req_fire;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign cur_pos   = ADDR_W'(ADDR_W'(row_ff) * ROW_STEP) + ADDR_W'(col_ff);
   assign src_addr  = cnt_ff + ROW_STEP;
   assign ram_wdata = wr_copy_ff ? rd_data : wr_data_ff;

   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      hw_in       = hw_ff;
      attr_in     = attr_ff;
      cnt_in      = cnt_ff;
      fill_rsp_in = fill_rsp_ff;
      scrolled_in = scrolled_ff;
      rd_ok_in    = rd_ok_ff;
      res_char_in = res_char_ff;
      res_attr_in = res_attr_ff;
      wr_en_in    = 1'b0;
      wr_addr_in  = wr_addr_ff;
      wr_copy_in  = 1'b0;
      wr_data_in  = wr_data_ff;
      rd_addr     = '0;

      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_hw_in    = rsp_hw_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_attr_in  = rsp_attr_ff;
      rsp_scr_in   = rsp_scr_ff;

      if (csr_chan.valid) begin
         attr_in = csr_chan.data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               req_in.func       = req_chan.func;
               req_in.chr        = req_chan.chr;
               req_in.cell_index = req_chan.cell_index;
               state_in          = S_EXEC;
            end
         end
         S_EXEC: begin
            scrolled_in = 1'b0;
            res_char_in = '0;
            res_attr_in = '0;
            state_in    = S_RESP;
            unique case (func_type'(req_ff.func))
               FUNC_PUT: begin
                  if (req_ff.chr == CHAR_NL || req_ff.chr == CHAR_CR) begin
                     col_in = '0;
                     if (req_ff.chr == CHAR_NL) begin
                        if (row_ff == LAST_ROW) begin
                           scrolled_in = 1'b1;
                        end else begin
                           row_in = row_ff + ROW_W'(1);
                        end
                     end
                  end else begin
                     wr_en_in   = 1'b1;
                     wr_addr_in = cur_pos;
                     wr_data_in = {attr_ff, req_ff.chr};
                     if (col_ff == LAST_COL) begin
                        col_in = '0;
                        if (row_ff == LAST_ROW) begin
                           scrolled_in = 1'b1;
                        end else begin
                           row_in = row_ff + ROW_W'(1);
                        end
                     end else begin
                        col_in = col_ff + COL_W'(1);
                     end
                  end
                  if (scrolled_in) begin
                     cnt_in   = '0;
                     state_in = S_FLUSH;
                  end
               end
               FUNC_CLEAR: begin
                  col_in      = '0;
                  row_in      = '0;
                  hw_in       = '0;
                  attr_in     = DEFAULT_ATTR;
                  cnt_in      = '0;
                  fill_rsp_in = 1'b1;
                  state_in    = S_FILL;
               end
               FUNC_LATCH: begin
                  hw_in = HW_W'(cur_pos);
               end
               FUNC_READ: begin
                  rd_ok_in = (32'(req_ff.cell_index) < 32'(NCELLS));
                  rd_addr  = rd_ok_in ? ADDR_W'(req_ff.cell_index) : '0;
                  state_in = S_READ;
               end
               default: state_in = S_RESP;
            endcase
         end
         S_FLUSH: begin
            // lets a pending character write land before the copy starts
            state_in = S_SCROLL;
         end
         S_SCROLL: begin
            wr_en_in   = 1'b1;
            wr_addr_in = cnt_ff;
            if (cnt_ff < COPY_LIM) begin
               rd_addr    = src_addr;
               wr_copy_in = 1'b1;
            end else begin
               wr_data_in = {attr_ff, BLANK_CHAR};
            end
            if (cnt_ff == LAST_ADDR) begin
               state_in = S_RESP;
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end
         S_FILL: begin
            wr_en_in   = 1'b1;
            wr_addr_in = cnt_ff;
            wr_data_in = {DEFAULT_ATTR, BLANK_CHAR};
            if (cnt_ff == LAST_ADDR) begin
               state_in = fill_rsp_ff ? S_RESP : S_IDLE;
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end
         S_READ: begin
            if (rd_ok_ff) begin
               res_char_in = rd_data[CHAR_W-1:0];
               res_attr_in = rd_data[CELL_W-1:CHAR_W];
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_col_in   = COL_FW'(col_ff);
               rsp_row_in   = ROW_FW'(row_ff);
               rsp_hw_in    = hw_ff;
               rsp_char_in  = res_char_ff;
               rsp_attr_in  = res_attr_ff;
               rsp_scr_in   = scrolled_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_FILL;
         col_ff       <= '0;
         row_ff       <= '0;
         hw_ff        <= '0;
         attr_ff      <= DEFAULT_ATTR;
         cnt_ff       <= '0;
         fill_rsp_ff  <= 1'b0;
         wr_en_ff     <= 1'b0;
         wr_copy_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         hw_ff        <= hw_in;
         attr_ff      <= attr_in;
         cnt_ff       <= cnt_in;
         fill_rsp_ff  <= fill_rsp_in;
         wr_en_ff     <= wr_en_in;
         wr_copy_ff   <= wr_copy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      scrolled_ff <= scrolled_in;
      rd_ok_ff    <= rd_ok_in;
      res_char_ff <= res_char_in;
      res_attr_ff <= res_attr_in;
      wr_addr_ff  <= wr_addr_in;
      wr_data_ff  <= wr_data_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_hw_ff   <= rsp_hw_in;
      rsp_char_ff <= rsp_char_in;
      rsp_attr_ff <= rsp_attr_in;
      rsp_scr_ff  <= rsp_scr_in;
   end

   tcw_ram #(
      .WIDTH(CELL_W),
      .DEPTH(NCELLS)
   ) u_screen (
      .clock  (clock),
      .wr_en  (wr_en_ff),
      .wr_addr(wr_addr_ff),
      .wr_data(ram_wdata),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.cursor_col    = rsp_col_ff;
   assign rsp_chan.cursor_row    = rsp_row_ff;
   assign rsp_chan.hw_cursor_pos = rsp_hw_ff;
   assign rsp_chan.cell_char     = rsp_char_ff;
   assign rsp_chan.cell_attr     = rsp_attr_ff;
   assign rsp_chan.scrolled      = rsp_scr_ff;

endmodule

`default_nettype wire
